[hw/rtl/qakp_pkg.sv]
// types, register indexes and quadrature decode for the axis key pulser
package qakp_pkg;

  localparam int KEY_W  = 16;
  localparam int ACC_W  = 10;
  localparam int HOLD_W = 10;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [ACC_W-1:0] ACC_STEP = 10'd16;
  localparam logic [ACC_W-1:0] ACC_MAX  = 10'd1023;
  localparam logic [3:0]       SINCE_MAX = 4'd15;

  // register indexes
  localparam logic [2:0] REG_GEAR     = 3'd0;
  localparam logic [2:0] REG_SENS     = 3'd1;
  localparam logic [2:0] REG_MIN_HOLD = 3'd2;
  localparam logic [2:0] REG_MAX_HOLD = 3'd3;
  localparam logic [2:0] REG_IDLE     = 3'd4;
  localparam logic [2:0] REG_KEY_POS  = 3'd5;
  localparam logic [2:0] REG_KEY_NEG  = 3'd6;
  localparam logic [2:0] REG_LOCKOUT  = 3'd7;

  // event kinds
  localparam logic EV_PRESS   = 1'b0;
  localparam logic EV_RELEASE = 1'b1;

  // step direction codes
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] DIR_NEG  = 2'b10;

  // transitions as {previous ab, current ab}
  localparam logic [3:0] POS_0 = 4'b1101;
  localparam logic [3:0] POS_1 = 4'b0100;
  localparam logic [3:0] POS_2 = 4'b0010;
  localparam logic [3:0] POS_3 = 4'b1011;
  localparam logic [3:0] NEG_0 = 4'b1110;
  localparam logic [3:0] NEG_1 = 4'b0111;
  localparam logic [3:0] NEG_2 = 4'b0001;
  localparam logic [3:0] NEG_3 = 4'b1000;

  typedef struct packed {
    logic pin_a;
    logic pin_b;
  } in_item_t;

  typedef struct packed {
    logic             event_kind;
    logic [KEY_W-1:0] key_code;
    logic             last;
  } out_item_t;

  function automatic logic [1:0] step_dir(input logic [3:0] trans);
    logic [1:0] d;
    case (trans) inside
      POS_0, POS_1, POS_2, POS_3: d = DIR_POS;
      NEG_0, NEG_1, NEG_2, NEG_3: d = DIR_NEG;
      default:                    d = DIR_NONE;
    endcase
    return d;
  endfunction

endpackage

[hw/rtl/quadrature_axis_key_pulser_top.sv]
// quadrature axis key pulser: encoder samples in, key press and release events out
//
// One input transfer is one tick carrying the sampled A and B pins. Each tick
// is decoded combinationally: lockout check, quadrature step decode, fixed-point
// accumulation against the gear ratio, hold time computation and the release
// check all sit in short logic between the state registers and a four-entry
// result queue. A tick produces zero, one or two result transfers (press,
// release, release of the old key followed by press of the new one, or press
// of a key followed by its release); the final result of a tick carries last.
// The input side takes a tick every clock as long as the queue holds at most
// two results, so ticks run at one per clock. The input stalls only while
// three or more results wait, which takes a run of two-event ticks or a
// receiver that holds off, while the result side drains one transfer per
// clock. Configuration writes are always taken and apply to the next tick;
// they are meant to be done with the block idle. KEY_BITS masks stored key
// codes, TIME_BITS sets the width of the saturating held and idle counters.
module quadrature_axis_key_pulser_top
  import qakp_pkg::*;
#(
  parameter int KEY_BITS  = 16,
  parameter int TIME_BITS = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [KEY_W-1:0] cfg_data
);

  // compare width that covers both the counters and the 11 bit idle limit
  localparam int CMP_W = (TIME_BITS > 11) ? TIME_BITS : 11;

  // configuration registers
  logic [8:0]          gear_r;
  logic [7:0]          sens_r;
  logic [8:0]          min_hold_r;
  logic [8:0]          max_hold_r;
  logic [10:0]         idle_lim_r;
  logic [KEY_BITS-1:0] key_pos_r;
  logic [KEY_BITS-1:0] key_neg_r;
  logic [3:0]          lockout_r;

  // axis state
  logic [1:0]           prev_ab_r, prev_ab_nxt;
  logic [3:0]           since_r, since_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [KEY_BITS-1:0]  active_r, active_nxt;
  logic [HOLD_W-1:0]    hold_r, hold_nxt;
  logic [TIME_BITS-1:0] held_r, held_nxt;
  logic [TIME_BITS-1:0] idle_r, idle_nxt;

  // result queue
  out_item_t         q_r [QDEPTH];
  logic [QPTR_W-1:0] rd_ptr_r, wr_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  // tick decode
  logic                 in_xfer, out_xfer;
  logic [1:0]           sample;
  logic [3:0]           elapsed;
  logic                 take;
  logic [1:0]           dir;
  logic                 step;
  logic [TIME_BITS-1:0] held_inc;
  logic [ACC_W:0]       acc_sum;
  logic [ACC_W-1:0]     acc_sat;
  logic                 fire;
  logic [KEY_BITS-1:0]  key_sel;
  logic [3:0]           extra;
  logic [8:0]           hold_span;
  logic                 press, rel_old, rel;
  logic [KEY_BITS-1:0]  active_mid;
  out_item_t            ev_a, ev_b;
  logic [1:0]           n_ev;

  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign in_ready  = cnt_r <= QCNT_W'(QDEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_data  = q_r[rd_ptr_r];
  assign cfg_ready = 1'b1;

  always_comb begin
    sample  = {in_data.pin_a, in_data.pin_b};
    // ticks since last step, saturating, and the lockout window
    elapsed = (since_r == SINCE_MAX) ? SINCE_MAX : since_r + 4'd1;
    take    = elapsed >= lockout_r;
    dir     = take ? step_dir({prev_ab_r, sample}) : DIR_NONE;
    step    = dir != DIR_NONE;

    prev_ab_nxt = take ? sample : prev_ab_r;
    since_nxt   = step ? 4'd0 : elapsed;
    held_inc    = (held_r == '1) ? held_r : held_r + 1'b1;
    idle_nxt    = step ? '0 : ((idle_r == '1) ? idle_r : idle_r + 1'b1);

    // accumulate one step, saturating
    acc_sum = {1'b0, acc_r} + {1'b0, ACC_STEP};
    acc_sat = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
    fire    = step && (acc_sat >= {1'b0, gear_r});
    key_sel = (dir == DIR_POS) ? key_pos_r : key_neg_r;

    // hold time: min plus integer sensitivity, capped at max - min when ordered
    extra     = sens_r[7:4];
    hold_span = max_hold_r - min_hold_r;
    if (max_hold_r >= min_hold_r && {5'd0, extra} > hold_span) begin
      extra = hold_span[3:0];
    end

    acc_nxt  = step ? acc_sat : acc_r;
    hold_nxt = hold_r;
    held_nxt = held_inc;
    press    = 1'b0;
    rel_old  = 1'b0;
    if (fire) begin
      hold_nxt = {1'b0, min_hold_r} + HOLD_W'(extra);
      held_nxt = '0;
      acc_nxt  = acc_sat - {1'b0, gear_r};
      press    = (key_sel != '0) && (key_sel != active_r);
      rel_old  = press && (active_r != '0);
    end
    active_mid = press ? key_sel : active_r;

    // release check, skipped on a key swap tick
    rel = (active_mid != '0) && !rel_old &&
          ((CMP_W'(held_nxt) >= CMP_W'(hold_nxt)) ||
           (CMP_W'(idle_nxt) >= CMP_W'(idle_lim_r)));
    active_nxt = rel ? '0 : active_mid;
    if (rel) begin
      acc_nxt = '0;
    end

    // order the events of this tick
    ev_a = '{event_kind: EV_RELEASE, key_code: KEY_W'(active_r), last: 1'b1};
    ev_b = '{event_kind: EV_PRESS, key_code: KEY_W'(key_sel), last: 1'b1};
    n_ev = 2'd0;
    if (rel_old) begin
      ev_a.last = 1'b0;
      n_ev      = 2'd2;
    end else if (press) begin
      ev_a = '{event_kind: EV_PRESS, key_code: KEY_W'(key_sel), last: !rel};
      ev_b = '{event_kind: EV_RELEASE, key_code: KEY_W'(key_sel), last: 1'b1};
      n_ev = rel ? 2'd2 : 2'd1;
    end else if (rel) begin
      n_ev = 2'd1;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gear_r     <= 9'd160;
      sens_r     <= 8'd32;
      min_hold_r <= 9'd50;
      max_hold_r <= 9'd200;
      idle_lim_r <= 11'd500;
      key_pos_r  <= KEY_BITS'(68);
      key_neg_r  <= KEY_BITS'(65);
      lockout_r  <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GEAR:     gear_r     <= cfg_data[8:0];
        REG_SENS:     sens_r     <= cfg_data[7:0];
        REG_MIN_HOLD: min_hold_r <= cfg_data[8:0];
        REG_MAX_HOLD: max_hold_r <= cfg_data[8:0];
        REG_IDLE:     idle_lim_r <= cfg_data[10:0];
        REG_KEY_POS:  key_pos_r  <= cfg_data[KEY_BITS-1:0];
        REG_KEY_NEG:  key_neg_r  <= cfg_data[KEY_BITS-1:0];
        REG_LOCKOUT:  lockout_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // axis state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ab_r <= '0;
      since_r   <= SINCE_MAX;
      acc_r     <= '0;
      active_r  <= '0;
      hold_r    <= '0;
      held_r    <= '0;
      idle_r    <= '0;
    end else if (in_xfer) begin
      prev_ab_r <= prev_ab_nxt;
      since_r   <= since_nxt;
      acc_r     <= acc_nxt;
      active_r  <= active_nxt;
      hold_r    <= hold_nxt;
      held_r    <= held_nxt;
      idle_r    <= idle_nxt;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (out_xfer) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (in_xfer) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(n_ev);
      end
      cnt_r <= cnt_r + (in_xfer ? QCNT_W'(n_ev) : '0) - QCNT_W'(out_xfer);
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (in_xfer && n_ev != 2'd0) begin
      q_r[wr_ptr_r] <= ev_a;
    end
    if (in_xfer && n_ev == 2'd2) begin
      q_r[wr_ptr_r + 1'b1] <= ev_b;
    end
  end

endmodule

[hw/rtl/qakp_chk.sv]
// port-level checks for the axis key pulser, bound to the top level
module qakp_chk
  import qakp_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input in_item_t         in_data,
  input logic             out_valid,
  input logic             out_ready,
  input out_item_t        out_data
);

  // a waiting tick keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("tick payload changed while stalled");

  // a waiting result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result payload changed while stalled");

  // reset leaves nothing to deliver
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // the input only stalls on a backlog of results
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no results queued");

  // events never carry the empty key code
  a_key_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.key_code != '0)
    else $error("event with key code zero");

endmodule

bind quadrature_axis_key_pulser_top qakp_chk u_qakp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
